// ===== design/round_robin_group_pairing_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin group pairing unit
// Shared assertion wrappers; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_GROUP_PAIRING_UNIT_DEFINES_SVH
`define ROUND_ROBIN_GROUP_PAIRING_UNIT_DEFINES_SVH

// checked only while out of reset
`define RRGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RRGP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rrgp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrgp_pkg
// Types and constants shared by the round-robin group pairing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrgp_pkg;

  localparam int MAX_GROUPS      = 64;
  localparam int MAX_GROUP_NODES = 256;

  localparam int ROUND_W = 16;
  localparam int PAIR_W  = 5;
  localparam int LOC_W   = 8;
  localparam int NODE_W  = 14;
  localparam int GC_W    = 7;
  localparam int NPG_W   = 9;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;
  localparam int GRP_W   = $clog2(MAX_GROUPS);
  localparam int REM_W   = $clog2(MAX_GROUP_NODES);
  localparam int PROD_W  = GRP_W + NPG_W;
  // quotient steps, then remainder-of-quotient steps
  localparam int DIV_STEPS = 2 * ROUND_W;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ODD   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_GROUP_COUNT = 2'd0,
    CFG_NODE_COUNT  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [ROUND_W-1:0] round;
    logic [PAIR_W-1:0]  pair;
    logic [LOC_W-1:0]   loc;
    status_t            status;
  } item_t;

  typedef struct packed {
    logic [ROUND_W-1:0] dvd;
    logic [ROUND_W-1:0] quo;
    logic [GRP_W-1:0]   ra;
    logic [REM_W-1:0]   rb;
    logic [PAIR_W-1:0]  pair;
    logic [LOC_W-1:0]   loc;
    status_t            status;
  } div_t;

  typedef struct packed {
    logic [GRP_W-1:0] g1;
    logic [GRP_W-1:0] g2;
    logic [LOC_W-1:0] loc;
    logic [LOC_W-1:0] loc2;
    status_t          status;
  } ord_t;

  typedef struct packed {
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    status_t           status;
  } lnk_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

`default_nettype wire

// ===== design/rrgp_front.sv =====
// ----------------------------------------------------------------------------
// rrgp_front
// Classifies an incoming item against the current configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module rrgp_front (
  input  wire logic [rrgp_pkg::ROUND_W-1:0] in_round,
  input  wire logic [rrgp_pkg::PAIR_W-1:0]  in_group_pair,
  input  wire logic [rrgp_pkg::LOC_W-1:0]   in_local_node,
  input  wire logic [rrgp_pkg::GC_W-1:0]    gc,
  input  wire logic [rrgp_pkg::NPG_W-1:0]   npg,
  output rrgp_pkg::item_t                   item
);

  logic bad_cfg;
  logic bad_idx;

  always_comb begin
    bad_cfg = (gc < rrgp_pkg::GC_W'(2)) ||
              (gc > rrgp_pkg::GC_W'(rrgp_pkg::MAX_GROUPS)) ||
              (npg == '0) ||
              (npg > rrgp_pkg::NPG_W'(rrgp_pkg::MAX_GROUP_NODES));
    bad_idx = ((rrgp_pkg::GC_W-1)'(in_group_pair) >= gc[rrgp_pkg::GC_W-1:1]) ||
              (rrgp_pkg::NPG_W'(in_local_node) >= npg);
    item.round = in_round;
    item.pair  = in_group_pair;
    item.loc   = in_local_node;
    // odd count wins over range errors
    priority if (gc[0]) begin
      item.status = rrgp_pkg::ST_ODD;
    end else if (bad_cfg || bad_idx) begin
      item.status = rrgp_pkg::ST_RANGE;
    end else begin
      item.status = rrgp_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

// ===== design/rrgp_queue.sv =====
// ----------------------------------------------------------------------------
// rrgp_queue
// Two-entry item queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_group_pairing_unit_defines.svh"

module rrgp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rrgp_pkg::item_t push_item,
  output logic                 full,
  output rrgp_pkg::qhead_t     head,
  input  wire logic            pop
);

  rrgp_pkg::item_t mem_r [rrgp_pkg::QUEUE_DEPTH];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == 2'(rrgp_pkg::QUEUE_DEPTH));
    head.valid = (cnt_r != '0);
    head.item  = mem_r[rp_r];
    wp_nxt     = push ? ~wp_r : wp_r;
    rp_nxt     = pop ? ~rp_r : rp_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  `RRGP_ASSERT(a_q_no_overflow, push |-> !full || pop, "queue push while full")
  `RRGP_ASSERT(a_q_no_underflow, pop |-> head.valid, "queue pop while empty")
  `RRGP_ASSERT(a_q_cnt_bound, cnt_r <= 2'(rrgp_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== design/rrgp_back.sv =====
// ----------------------------------------------------------------------------
// rrgp_back
// Arithmetic pipeline: round / (G-1), quotient mod N, circle order, node ids.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_group_pairing_unit_defines.svh"

module rrgp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rrgp_pkg::GC_W-1:0]   gc,
  input  wire logic [rrgp_pkg::NPG_W-1:0]  npg,
  input  wire rrgp_pkg::qhead_t            head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rrgp_pkg::NODE_W-1:0]      out_low_node,
  output logic [rrgp_pkg::NODE_W-1:0]      out_high_node,
  output logic [1:0]                       out_status
);

  localparam int NS = rrgp_pkg::DIV_STEPS;
  localparam int RW = rrgp_pkg::ROUND_W;
  localparam int GW = rrgp_pkg::GRP_W;
  localparam int BW = rrgp_pkg::REM_W;

  logic                     adv;
  logic [GW:0]              div_a;
  rrgp_pkg::div_t           seed;
  rrgp_pkg::div_t           st_r [NS];
  logic [NS-1:0]            sv_r;

  rrgp_pkg::ord_t           ord_r, ord_nxt;
  logic                     ord_v_r;
  rrgp_pkg::lnk_t           lnk_r, lnk_nxt;
  logic                     lnk_v_r;
  logic [rrgp_pkg::NODE_W-1:0] low_r, low_nxt, high_r, high_nxt;
  rrgp_pkg::status_t        stat_r, stat_nxt;
  logic                     out_valid_r;

  // whole pipeline freezes while a result waits on a stalled receiver
  assign adv   = !out_valid_r || !out_stall;
  assign pop   = adv && head.valid;
  assign div_a = (GW+1)'(gc - rrgp_pkg::GC_W'(1));

  always_comb begin
    seed.dvd    = head.item.round;
    seed.quo    = '0;
    seed.ra     = '0;
    seed.rb     = '0;
    seed.pair   = head.item.pair;
    seed.loc    = head.item.loc;
    seed.status = head.item.status;
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    rrgp_pkg::div_t src, nxt;
    logic [GW:0]    ra_t;
    logic [BW:0]    rb_t;

    if (k == 0) begin : g_src0
      assign src = seed;
    end else begin : g_srcn
      assign src = st_r[k-1];
    end

    always_comb begin
      nxt  = src;
      ra_t = {src.ra, src.dvd[RW-1]};
      rb_t = {src.rb, src.dvd[RW-1]};
      nxt.dvd = {src.dvd[RW-2:0], 1'b0};
      if (k < RW) begin
        // restoring step of round / (G-1)
        if (ra_t >= div_a) begin
          nxt.ra  = GW'(ra_t - div_a);
          nxt.quo = {src.quo[RW-2:0], 1'b1};
        end else begin
          nxt.ra  = ra_t[GW-1:0];
          nxt.quo = {src.quo[RW-2:0], 1'b0};
        end
        // quotient becomes the dividend of the mod-N pass
        if (k == RW - 1) begin
          nxt.dvd = nxt.quo;
        end
      end else begin
        if (rrgp_pkg::NPG_W'(rb_t) >= npg) begin
          nxt.rb = BW'(rrgp_pkg::NPG_W'(rb_t) - npg);
        end else begin
          nxt.rb = rb_t[BW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (adv) begin
        sv_r[k] <= (k == 0) ? head.valid : sv_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= nxt;
      end
    end
  end

  function automatic logic [GW-1:0] circle_order(input logic [GW-1:0] k,
                                                 input logic [GW-1:0] rounds,
                                                 input logic [GW-1:0] back);
    logic [GW:0] t;
    t = (GW+1)'(k) - (GW+1)'(1) + (GW+1)'(rounds) - (GW+1)'(back);
    if (t >= (GW+1)'(rounds)) begin
      t = t - (GW+1)'(rounds);
    end
    if (k == '0) begin
      return '0;
    end
    return GW'(t + (GW+1)'(1));
  endfunction

  always_comb begin
    logic [GW-1:0]            rounds;
    logic [GW-1:0]            k2;
    logic [rrgp_pkg::NPG_W-1:0] l2;
    rounds  = GW'(gc - rrgp_pkg::GC_W'(1));
    k2      = GW'(gc - rrgp_pkg::GC_W'(1) - rrgp_pkg::GC_W'(st_r[NS-1].pair));
    l2      = rrgp_pkg::NPG_W'(st_r[NS-1].loc) + rrgp_pkg::NPG_W'(st_r[NS-1].rb);
    if (l2 >= npg) begin
      l2 = l2 - npg;
    end
    ord_nxt.g1     = circle_order(GW'(st_r[NS-1].pair), rounds, st_r[NS-1].ra);
    ord_nxt.g2     = circle_order(k2, rounds, st_r[NS-1].ra);
    ord_nxt.loc    = st_r[NS-1].loc;
    ord_nxt.loc2   = rrgp_pkg::LOC_W'(l2);
    ord_nxt.status = st_r[NS-1].status;
  end

  always_comb begin
    logic [rrgp_pkg::PROD_W-1:0] pu, pv;
    pu = rrgp_pkg::PROD_W'(ord_r.g1) * rrgp_pkg::PROD_W'(npg)
         + rrgp_pkg::PROD_W'(ord_r.loc);
    pv = rrgp_pkg::PROD_W'(ord_r.g2) * rrgp_pkg::PROD_W'(npg)
         + rrgp_pkg::PROD_W'(ord_r.loc2);
    lnk_nxt.u      = pu[rrgp_pkg::NODE_W-1:0];
    lnk_nxt.v      = pv[rrgp_pkg::NODE_W-1:0];
    lnk_nxt.status = ord_r.status;
  end

  always_comb begin
    stat_nxt = lnk_r.status;
    if (lnk_r.status != rrgp_pkg::ST_OK) begin
      low_nxt  = '0;
      high_nxt = '0;
    end else if (lnk_r.u > lnk_r.v) begin
      low_nxt  = lnk_r.v;
      high_nxt = lnk_r.u;
    end else begin
      low_nxt  = lnk_r.u;
      high_nxt = lnk_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_v_r     <= 1'b0;
      lnk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ord_v_r     <= sv_r[NS-1];
      lnk_v_r     <= ord_v_r;
      out_valid_r <= lnk_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ord_r  <= ord_nxt;
      lnk_r  <= lnk_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_low_node  = low_r;
  assign out_high_node = high_r;
  assign out_status    = stat_r;

  `RRGP_ASSERT(a_b_ordered, out_valid_r |-> low_r <= high_r, "link ids out of order")
  `RRGP_ASSERT(a_b_err_zero,
    out_valid_r && (stat_r != rrgp_pkg::ST_OK) |-> (low_r == '0) && (high_r == '0),
    "error result carries nonzero ids")
  `RRGP_ASSERT_ALWAYS(a_b_rst_idle, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

`default_nettype wire

// ===== design/round_robin_group_pairing_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_group_pairing_unit
// Circle-method group pairing: one circuit-switch link per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes round, group_pair, local_node.
// Result channel (out_valid/out_stall) gives low_node, high_node, status.
// Config: cfg_we with cfg_idx 0 = group count, 1 = nodes in each group; other
// indexes are ignored. Write only while no item is in flight.
// Throughput: one item per cycle unless out_stall holds the pipeline. The
// two bit-serial divide chains (16 steps for round / (G-1), 16 steps for the
// quotient mod N) are fully pipelined. An accepted item is written into the
// queue, then passes the 32 divide steps, the circle-order register, the
// node-multiply register and the output register before out_valid rises.
// Reset: pipeline emptied, group count = 2, nodes in each group = 1.
// While a result waits on a high out_stall the whole pipeline holds; the
// two-entry queue keeps taking items until full, then raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_group_pairing_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rrgp_pkg::CIDX_W-1:0]    cfg_idx,
  input  wire logic [rrgp_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rrgp_pkg::ROUND_W-1:0]   in_round,
  input  wire logic [rrgp_pkg::PAIR_W-1:0]    in_group_pair,
  input  wire logic [rrgp_pkg::LOC_W-1:0]     in_local_node,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rrgp_pkg::NODE_W-1:0]         out_low_node,
  output logic [rrgp_pkg::NODE_W-1:0]         out_high_node,
  output logic [1:0]                          out_status
);

  logic [rrgp_pkg::GC_W-1:0]  gc_r, gc_nxt;
  logic [rrgp_pkg::NPG_W-1:0] npg_r, npg_nxt;
  rrgp_pkg::item_t            item;
  rrgp_pkg::qhead_t           head;
  logic                       full;
  logic                       pop;

  always_comb begin
    gc_nxt  = gc_r;
    npg_nxt = npg_r;
    if (cfg_we) begin
      unique case (rrgp_pkg::cfg_idx_t'(cfg_idx))
        rrgp_pkg::CFG_GROUP_COUNT: gc_nxt  = cfg_wdata[rrgp_pkg::GC_W-1:0];
        rrgp_pkg::CFG_NODE_COUNT:  npg_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r  <= rrgp_pkg::GC_W'(2);
      npg_r <= rrgp_pkg::NPG_W'(1);
    end else begin
      gc_r  <= gc_nxt;
      npg_r <= npg_nxt;
    end
  end

  assign in_stall = full;

  rrgp_front u_front (
    .in_round      (in_round),
    .in_group_pair (in_group_pair),
    .in_local_node (in_local_node),
    .gc            (gc_r),
    .npg           (npg_r),
    .item          (item)
  );

  rrgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !full),
    .push_item (item),
    .full      (full),
    .head      (head),
    .pop       (pop)
  );

  rrgp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .gc            (gc_r),
    .npg           (npg_r),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_low_node  (out_low_node),
    .out_high_node (out_high_node),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Round-robin group pairing unit testbench
// Drives pairing requests under several group/node configurations with random
// idling on both channels and checks every link against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 50;
  localparam logic [rrgp_pkg::CIDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [rrgp_pkg::NODE_W-1:0] low;
    logic [rrgp_pkg::NODE_W-1:0] high;
    rrgp_pkg::status_t           status;
  } link_t;

  typedef struct {
    logic [rrgp_pkg::ROUND_W-1:0] round;
    logic [rrgp_pkg::PAIR_W-1:0]  pair;
    logic [rrgp_pkg::LOC_W-1:0]   loc;
    bit                           typed;
    link_t                        link;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rrgp_pkg::CIDX_W-1:0] cfg_idx = '0;
  logic [rrgp_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rrgp_pkg::ROUND_W-1:0] in_round = '0;
  logic [rrgp_pkg::PAIR_W-1:0] in_group_pair = '0;
  logic [rrgp_pkg::LOC_W-1:0] in_local_node = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rrgp_pkg::NODE_W-1:0] out_low_node;
  logic [rrgp_pkg::NODE_W-1:0] out_high_node;
  logic [1:0] out_status;

  int unsigned groups = 2;
  int unsigned nodes = 1;
  link_t pending_links[$];
  int errors = 0;
  int links_seen = 0;
  int ok_seen = 0;
  bit hold_off = 1'b0;
  bit in_busy = 1'b0;
  int unsigned rx_wait = 0;

  round_robin_group_pairing_unit u_top (.*);

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned circle_slot(int unsigned k, int unsigned rnd,
                                              int unsigned span);
    if (k == 0) return 0;
    return 1 + ((k - 1) + span - (rnd % span)) % span;
  endfunction

  function automatic link_t pair_link(int unsigned rnd, int unsigned pair,
                                      int unsigned loc);
    link_t r;
    int unsigned span, shift, a, b, t;
    r = '{low: '0, high: '0, status: rrgp_pkg::ST_OK};
    if (groups[0]) begin
      r.status = rrgp_pkg::ST_ODD;
      return r;
    end
    if (groups < 2 || groups > rrgp_pkg::MAX_GROUPS || nodes == 0 ||
        nodes > rrgp_pkg::MAX_GROUP_NODES || pair >= groups / 2 || loc >= nodes) begin
      r.status = rrgp_pkg::ST_RANGE;
      return r;
    end
    span = groups - 1;
    shift = (rnd / span) % nodes;
    a = circle_slot(pair, rnd, span) * nodes + loc;
    b = circle_slot(groups - 1 - pair, rnd, span) * nodes + (loc + shift) % nodes;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    r.low = a[rrgp_pkg::NODE_W-1:0];
    r.high = b[rrgp_pkg::NODE_W-1:0];
    return r;
  endfunction

  task automatic write_reg(rrgp_pkg::cfg_idx_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[rrgp_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rrgp_pkg::CFG_GROUP_COUNT) groups = value & 'h7f;
    else if (idx == rrgp_pkg::CFG_NODE_COUNT) nodes = value & 'h1ff;
    @(posedge clk);
  endtask

  task automatic write_unused(int unsigned value);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SPARE_IDX;
    cfg_wdata <= value[rrgp_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid only if an item was left driven
  task automatic idle_input;
    if (in_busy) begin
      in_valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  // one item: random gap, then hold until accepted
  task automatic send_item(logic [rrgp_pkg::ROUND_W-1:0] rnd,
                           logic [rrgp_pkg::PAIR_W-1:0] pair,
                           logic [rrgp_pkg::LOC_W-1:0] loc);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap != 0) begin
      idle_input();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_busy = 1'b1;
    in_round <= rnd;
    in_group_pair <= pair;
    in_local_node <= loc;
    pending_links.insert(pending_links.size(), pair_link(rnd, pair, loc));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    int waited;
    waited = 0;
    idle_input();
    while (pending_links.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(int count);
    int unsigned p, l;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        p = $urandom_range(0, 31);
        l = $urandom_range(0, 255);
      end else begin
        p = $urandom_range(0, (groups >= 2 ? groups / 2 : 1) - 1);
        l = $urandom_range(0, (nodes >= 1 && nodes <= 256 ? nodes : 1) - 1);
      end
      send_item(rrgp_pkg::ROUND_W'($urandom_range(0, 65535)),
                p[rrgp_pkg::PAIR_W-1:0], l[rrgp_pkg::LOC_W-1:0]);
    end
  endtask

  // receiver: a random wait per item, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_wait = $urandom_range(0, 7);
      out_stall <= (rx_wait != 0);
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_stall <= (rx_wait != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    link_t want;
    if (rst_n && out_valid && !out_stall) begin
      links_seen++;
      if (pending_links.size() == 0) begin
        $error("link with nothing pending: low %0d high %0d status %0d",
               out_low_node, out_high_node, out_status);
        errors++;
      end else begin
        want = pending_links.pop_front();
        if (want.status == rrgp_pkg::ST_OK) ok_seen++;
        if (out_low_node !== want.low) begin
          $error("low_node expected %0d actual %0d", want.low, out_low_node);
          errors++;
        end
        if (out_high_node !== want.high) begin
          $error("high_node expected %0d actual %0d", want.high, out_high_node);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    link_t got;
    int cfg_g[8] = '{4, 64, 2, 10, 64, 6, 32, 2};
    int cfg_n[8] = '{3, 256, 256, 1, 1, 17, 100, 7};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: G=2, N=1, a single possible link 0-1
    rows.insert(rows.size(), '{16'd0, 5'd0, 8'd0, 1'b1, '{14'd0, 14'd1, rrgp_pkg::ST_OK}});
    rows.insert(rows.size(), '{16'hffff, 5'd0, 8'd0, 1'b1,
                               '{14'd0, 14'd1, rrgp_pkg::ST_OK}});
    rows.insert(rows.size(), '{16'd5, 5'd1, 8'd0, 1'b1,
                               '{14'd0, 14'd0, rrgp_pkg::ST_RANGE}});
    rows.insert(rows.size(), '{16'd5, 5'd0, 8'd1, 1'b1,
                               '{14'd0, 14'd0, rrgp_pkg::ST_RANGE}});
    rows.insert(rows.size(), '{16'd0, 5'd31, 8'd255, 1'b1,
                               '{14'd0, 14'd0, rrgp_pkg::ST_RANGE}});
    foreach (rows[i]) begin
      got = pair_link(rows[i].round, rows[i].pair, rows[i].loc);
      if (rows[i].typed && got != rows[i].link) begin
        $error("table row %0d disagrees with prediction", i);
        errors++;
      end
      send_item(rows[i].round, rows[i].pair, rows[i].loc);
    end
    drain();

    // odd count, out-of-range configs, unused register index
    write_reg(rrgp_pkg::CFG_GROUP_COUNT, 7);
    send_item(16'd3, 5'd0, 8'd0);
    send_item(16'hffff, 5'd31, 8'd255);
    drain();
    write_reg(rrgp_pkg::CFG_GROUP_COUNT, 0);
    send_item(16'd1, 5'd0, 8'd0);
    drain();
    write_reg(rrgp_pkg::CFG_GROUP_COUNT, 66);
    write_reg(rrgp_pkg::CFG_NODE_COUNT, 0);
    send_item(16'd1, 5'd0, 8'd0);
    drain();
    write_reg(rrgp_pkg::CFG_GROUP_COUNT, 64);
    send_item(16'd1, 5'd0, 8'd0);
    drain();
    write_reg(rrgp_pkg::CFG_NODE_COUNT, 511);
    send_item(16'd1, 5'd0, 8'd0);
    drain();
    write_unused(9'h1ff);
    write_reg(rrgp_pkg::CFG_GROUP_COUNT, 127);
    send_item(16'd1, 5'd0, 8'd0);
    drain();

    // max config corners
    write_reg(rrgp_pkg::CFG_GROUP_COUNT, 64);
    write_reg(rrgp_pkg::CFG_NODE_COUNT, 256);
    send_item(16'hffff, 5'd31, 8'd255);
    send_item(16'd0, 5'd0, 8'd0);
    send_item(16'h8000, 5'd16, 8'd128);
    send_item(16'h7fff, 5'd15, 8'd127);
    send_item(16'h5555, 5'd10, 8'h55);
    send_item(16'haaaa, 5'd21, 8'haa);
    drain();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        random_items(40);
        idle_input();
      end
    join
    drain();

    foreach (cfg_g[i]) begin
      write_reg(rrgp_pkg::CFG_GROUP_COUNT, cfg_g[i]);
      write_reg(rrgp_pkg::CFG_NODE_COUNT, cfg_n[i]);
      random_items(155);
      drain();
    end

    $display("ran %0d links (%0d valid pairings) over 8 random configs plus corners",
             links_seen, ok_seen);
    if (errors == 0 && pending_links.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
